// File: rtl/core/osr_pkg.sv
package osr_pkg;

  localparam int unsigned DEPTH   = 4096;
  localparam int unsigned MAX_POP = 64;

  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W  = $clog2(DEPTH + 1);
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned MEM_W   = 2 * SMP_W;
  localparam int unsigned ZC_W    = 16;
  localparam int unsigned PC_W    = 7;
  localparam int unsigned LOST_W  = 16;
  localparam int unsigned LVL_W   = 32;
  localparam int unsigned SUM_W   = ((ZC_W > FILL_W) ? ZC_W : FILL_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_ZEROS = 2'd1,
    OP_POP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_RES,
    S_PAD,
    S_RD,
    S_DAT
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [MEM_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: rtl/core/osr_if.sv
interface osr_req_if;
  logic                              valid;
  logic                              ready;
  logic [osr_pkg::OP_W-1:0]          opcode;
  logic signed [osr_pkg::SMP_W-1:0]  in_real;
  logic signed [osr_pkg::SMP_W-1:0]  in_imag;
  logic [osr_pkg::ZC_W-1:0]          zero_count;
  logic [osr_pkg::PC_W-1:0]          pop_count;

  modport source (output valid, opcode, in_real, in_imag, zero_count, pop_count,
                  input ready);
  modport sink (input valid, opcode, in_real, in_imag, zero_count, pop_count,
                output ready);
endinterface

interface osr_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [osr_pkg::SMP_W-1:0]  out_real;
  logic signed [osr_pkg::SMP_W-1:0]  out_imag;
  logic                              sample_valid;
  logic                              from_padding;
  logic                              last_of_run;
  logic [osr_pkg::LOST_W-1:0]        lost_now;
  logic [osr_pkg::LVL_W-1:0]         level;

  modport source (output valid, out_real, out_imag, sample_valid, from_padding,
                  last_of_run, lost_now, level, input ready);
  modport sink (input valid, out_real, out_imag, sample_valid, from_padding,
                last_of_run, lost_now, level, output ready);
endinterface

// File: rtl/core/osr_ram.sv
module osr_ram (
  input  logic                           clk_i,
  input  osr_pkg::mem_req_t              mem_req_i,
  output logic [osr_pkg::MEM_W-1:0]      rd_data_o
);

  logic [osr_pkg::MEM_W-1:0] mem [osr_pkg::DEPTH];
  logic [osr_pkg::MEM_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rd_data_q <= mem[mem_req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/osr_ctrl.sv
module osr_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  osr_req_if.sink                   req_i,
  osr_rsp_if.source                 rsp_o,
  output osr_pkg::mem_req_t         mem_req_o,
  input  logic [osr_pkg::MEM_W-1:0] rd_data_i
);

  function automatic logic [osr_pkg::ADDR_W-1:0] inc_ptr(
      input logic [osr_pkg::ADDR_W-1:0] ptr);
    return (ptr == osr_pkg::ADDR_W'(osr_pkg::DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  function automatic logic [osr_pkg::LVL_W-1:0] sat_add(
      input logic [osr_pkg::LVL_W-1:0] a, input logic [osr_pkg::SUM_W-1:0] b);
    logic [osr_pkg::LVL_W:0] s;
    s = {1'b0, a} + (osr_pkg::LVL_W + 1)'(b);
    return s[osr_pkg::LVL_W] ? '1 : s[osr_pkg::LVL_W-1:0];
  endfunction

  osr_pkg::state_e state_q, state_d;

  logic [osr_pkg::ADDR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [osr_pkg::FILL_W-1:0] fill_q, fill_d, cnt_q, cnt_d;
  logic [osr_pkg::LVL_W-1:0]  pend_q, pend_d;
  logic [osr_pkg::PC_W-1:0]   pad_q, pad_d, smp_q, smp_d;
  logic [osr_pkg::LOST_W-1:0] lost_q, lost_d;
  logic                       ovf_q, ovf_d;

  logic                              o_valid_q, o_valid_d;
  logic signed [osr_pkg::SMP_W-1:0]  o_real_q, o_imag_q;
  logic                              o_smp_q, o_pad_q, o_last_q;
  logic [osr_pkg::LOST_W-1:0]        o_lost_q;
  logic [osr_pkg::LVL_W-1:0]         o_level_q;

  logic                              ld;
  logic signed [osr_pkg::SMP_W-1:0]  ld_real, ld_imag;
  logic                              ld_smp, ld_pad, ld_last;
  logic [osr_pkg::LOST_W-1:0]        ld_lost;
  logic [osr_pkg::LVL_W-1:0]         ld_level;

  logic                       out_free, accept, full;
  logic [osr_pkg::FILL_W-1:0] push_fill;
  logic [osr_pkg::LVL_W-1:0]  push_pend, level_now;
  logic [osr_pkg::SUM_W-1:0]  zc_w, excess, zsum, lostz;
  logic [osr_pkg::FILL_W-1:0] zn;
  logic                       zovf;
  logic [osr_pkg::PC_W-1:0]   want, nz, rem, ns;

  assign out_free    = !o_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == osr_pkg::S_IDLE) && out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign level_now   = sat_add(pend_q, osr_pkg::SUM_W'(fill_q));

  always_comb begin
    full      = (fill_q == osr_pkg::FILL_W'(osr_pkg::DEPTH));
    push_fill = full ? fill_q : fill_q + 1'b1;
    push_pend = sat_add(pend_q, osr_pkg::SUM_W'(full));

    zc_w   = osr_pkg::SUM_W'(req_i.zero_count);
    excess = (zc_w > osr_pkg::SUM_W'(osr_pkg::DEPTH)) ?
             zc_w - osr_pkg::SUM_W'(osr_pkg::DEPTH) : '0;
    zn     = (zc_w > osr_pkg::SUM_W'(osr_pkg::DEPTH)) ?
             osr_pkg::FILL_W'(osr_pkg::DEPTH) : osr_pkg::FILL_W'(zc_w);
    zsum   = osr_pkg::SUM_W'(fill_q) + osr_pkg::SUM_W'(zn);
    zovf   = (zsum > osr_pkg::SUM_W'(osr_pkg::DEPTH));
    lostz  = excess + (zovf ? zsum - osr_pkg::SUM_W'(osr_pkg::DEPTH) : '0);

    want = (req_i.pop_count > osr_pkg::PC_W'(osr_pkg::MAX_POP)) ?
           osr_pkg::PC_W'(osr_pkg::MAX_POP) : req_i.pop_count;
    nz   = (pend_q < osr_pkg::LVL_W'(want)) ? osr_pkg::PC_W'(pend_q) : want;
    rem  = want - nz;
    ns   = (osr_pkg::SUM_W'(fill_q) < osr_pkg::SUM_W'(rem)) ?
           osr_pkg::PC_W'(fill_q) : rem;
  end

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    fill_d   = fill_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    pad_d    = pad_q;
    smp_d    = smp_q;
    lost_d   = lost_q;
    ovf_d    = ovf_q;
    ld       = 1'b0;
    ld_real  = '0;
    ld_imag  = '0;
    ld_smp   = 1'b0;
    ld_pad   = 1'b0;
    ld_last  = 1'b1;
    ld_lost  = '0;
    ld_level = level_now;
    mem_req_o = '0;

    unique case (state_q)
      osr_pkg::S_IDLE: begin
        if (accept) begin
          unique case (osr_pkg::op_e'(req_i.opcode))
            osr_pkg::OP_PUSH: begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = wp_q;
              mem_req_o.wdata = {req_i.in_imag, req_i.in_real};
              wp_d            = inc_ptr(wp_q);
              if (full) begin
                rp_d = inc_ptr(rp_q);
              end
              fill_d   = push_fill;
              pend_d   = push_pend;
              ld       = 1'b1;
              ld_lost  = osr_pkg::LOST_W'(full);
              ld_level = sat_add(push_pend, osr_pkg::SUM_W'(push_fill));
            end
            osr_pkg::OP_ZEROS: begin
              lost_d = (lostz > osr_pkg::SUM_W'({osr_pkg::LOST_W{1'b1}})) ?
                       '1 : osr_pkg::LOST_W'(lostz);
              ovf_d  = zovf;
              cnt_d  = zn;
              fill_d = zovf ? osr_pkg::FILL_W'(osr_pkg::DEPTH) : osr_pkg::FILL_W'(zsum);
              pend_d = sat_add(pend_q, lostz);
              state_d = (zn == '0) ? osr_pkg::S_RES : osr_pkg::S_WALK;
            end
            osr_pkg::OP_POP: begin
              pend_d = pend_q - osr_pkg::LVL_W'(nz);
              fill_d = fill_q - osr_pkg::FILL_W'(ns);
              pad_d  = nz;
              smp_d  = ns;
              lost_d = '0;
              if (nz != '0) begin
                state_d = osr_pkg::S_PAD;
              end else if (ns != '0) begin
                state_d = osr_pkg::S_RD;
              end else begin
                state_d = osr_pkg::S_RES;
              end
            end
            osr_pkg::OP_CLEAR: begin
              wp_d     = '0;
              rp_d     = '0;
              fill_d   = '0;
              pend_d   = '0;
              ld       = 1'b1;
              ld_level = '0;
            end
          endcase
        end
      end
      osr_pkg::S_WALK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = wp_q;
        wp_d            = inc_ptr(wp_q);
        cnt_d           = cnt_q - 1'b1;
        if (cnt_q == osr_pkg::FILL_W'(1)) begin
          if (ovf_q) begin
            rp_d = inc_ptr(wp_q);
          end
          state_d = osr_pkg::S_RES;
        end
      end
      osr_pkg::S_RES: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_lost = lost_q;
          state_d = osr_pkg::S_IDLE;
        end
      end
      osr_pkg::S_PAD: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_smp  = 1'b1;
          ld_pad  = 1'b1;
          ld_last = (pad_q == osr_pkg::PC_W'(1)) && (smp_q == '0);
          pad_d   = pad_q - 1'b1;
          if (pad_q == osr_pkg::PC_W'(1)) begin
            state_d = (smp_q != '0) ? osr_pkg::S_RD : osr_pkg::S_IDLE;
          end
        end
      end
      osr_pkg::S_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = rp_q;
        rp_d            = inc_ptr(rp_q);
        state_d         = osr_pkg::S_DAT;
      end
      osr_pkg::S_DAT: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_smp  = 1'b1;
          ld_real = $signed(rd_data_i[osr_pkg::SMP_W-1:0]);
          ld_imag = $signed(rd_data_i[osr_pkg::MEM_W-1:osr_pkg::SMP_W]);
          ld_last = (smp_q == osr_pkg::PC_W'(1));
          smp_d   = smp_q - 1'b1;
          if (smp_q == osr_pkg::PC_W'(1)) begin
            state_d = osr_pkg::S_IDLE;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = rp_q;
            rp_d            = inc_ptr(rp_q);
          end
        end
      end
      default: begin
        state_d = osr_pkg::S_IDLE;
      end
    endcase

    o_valid_d = ld ? 1'b1 : (o_valid_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= osr_pkg::S_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      fill_q    <= '0;
      pend_q    <= '0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      fill_q    <= fill_d;
      pend_q    <= pend_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    pad_q  <= pad_d;
    smp_q  <= smp_d;
    lost_q <= lost_d;
    ovf_q  <= ovf_d;
    if (ld) begin
      o_real_q  <= ld_real;
      o_imag_q  <= ld_imag;
      o_smp_q   <= ld_smp;
      o_pad_q   <= ld_pad;
      o_last_q  <= ld_last;
      o_lost_q  <= ld_lost;
      o_level_q <= ld_level;
    end
  end

  assign rsp_o.valid        = o_valid_q;
  assign rsp_o.out_real     = o_real_q;
  assign rsp_o.out_imag     = o_imag_q;
  assign rsp_o.sample_valid = o_smp_q;
  assign rsp_o.from_padding = o_pad_q;
  assign rsp_o.last_of_run  = o_last_q;
  assign rsp_o.lost_now     = o_lost_q;
  assign rsp_o.level        = o_level_q;

endmodule

// File: rtl/core/overwrite_sample_ring_with_zero_padding.sv
// Overwriting ring of 4096 complex 16-bit samples with a pending-zero
// counter. Each request pushes one sample, pushes a burst of zeros, pops up
// to 64 samples, or clears the ring; a push into a full ring drops the oldest
// samples and owes them back as zeros that the next pops hand out first.
// A sample push or a clear is accepted while idle and its single result is
// ready on the next cycle, so pushes stream at one request per cycle as long
// as results are taken. A pop holds off the next request until its last
// result is loaded: results leave at one per cycle while the receiver takes
// them, owed zeros first, and a memory read state comes before the first
// stored sample. A pop that yields nothing still returns one final result.
// A zero burst of n samples writes the ring through its single write port,
// one entry per cycle for up to 4096 entries, and then returns one result.
// The sample memory needs no initialization after reset.
module overwrite_sample_ring_with_zero_padding (
  input  logic        clk_i,
  input  logic        rst_ni,
  osr_req_if.sink     req_i,
  osr_rsp_if.source   rsp_o
);

  osr_pkg::mem_req_t         mem_req;
  logic [osr_pkg::MEM_W-1:0] rd_data;

  osr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .mem_req_o (mem_req),
    .rd_data_i (rd_data)
  );

  osr_ram u_ram (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

// File: rtl/core/osr_chk.sv
module osr_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             req_valid_i,
  input logic                             req_ready_i,
  input logic [osr_pkg::OP_W-1:0]         req_opcode_i,
  input logic                             rsp_valid_i,
  input logic                             rsp_ready_i,
  input logic [osr_pkg::SMP_W-1:0]        rsp_real_i,
  input logic [osr_pkg::SMP_W-1:0]        rsp_imag_i,
  input logic                             rsp_smp_i,
  input logic                             rsp_pad_i,
  input logic                             rsp_last_i,
  input logic [osr_pkg::LOST_W-1:0]       rsp_lost_i,
  input logic [osr_pkg::LVL_W-1:0]        rsp_level_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_real_i) &&
      $stable(rsp_imag_i) && $stable(rsp_smp_i) && $stable(rsp_pad_i) &&
      $stable(rsp_last_i) && $stable(rsp_lost_i) && $stable(rsp_level_i))
    else $error("Stalled result changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_smp_i |-> rsp_last_i && !rsp_pad_i &&
      rsp_real_i == '0 && rsp_imag_i == '0)
    else $error("Result without a sample is not a plain final result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_pad_i |-> rsp_smp_i && rsp_real_i == '0 &&
      rsp_imag_i == '0 && rsp_lost_i == '0)
    else $error("Padding result carries data or a loss count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_opcode_i == osr_pkg::OP_CLEAR |=>
      rsp_valid_i && rsp_level_i == '0 && rsp_lost_i == '0 && rsp_last_i)
    else $error("Clear did not report an empty ring.");

endmodule

bind overwrite_sample_ring_with_zero_padding osr_chk u_osr_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_opcode_i (req_i.opcode),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_real_i   (rsp_o.out_real),
  .rsp_imag_i   (rsp_o.out_imag),
  .rsp_smp_i    (rsp_o.sample_valid),
  .rsp_pad_i    (rsp_o.from_padding),
  .rsp_last_i   (rsp_o.last_of_run),
  .rsp_lost_i   (rsp_o.lost_now),
  .rsp_level_i  (rsp_o.level)
);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import osr_pkg::*;

  typedef struct {
    logic signed [SMP_W-1:0] out_real;
    logic signed [SMP_W-1:0] out_imag;
    logic                    sample_valid;
    logic                    from_padding;
    logic                    last_of_run;
    logic [LOST_W-1:0]       lost_now;
    logic [LVL_W-1:0]        level;
  } ring_rsp_t;

  logic clk;
  logic rst_n;

  osr_req_if req ();
  osr_rsp_if rsp ();

  overwrite_sample_ring_with_zero_padding dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  logic [MEM_W-1:0]  ring_mem [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  int unsigned       fill_cnt;
  logic [LVL_W-1:0]  owed_zeros;
  ring_rsp_t         rsp_due [$];
  int unsigned       err_cnt;
  bit                idle_on;
  int unsigned       hold_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [LVL_W-1:0] sat_level(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? '1 : LVL_W'(v);
  endfunction

  // Writes n entries at the write pointer and returns how many stored
  // samples were overwritten.
  function automatic longint unsigned write_run(int unsigned n, logic [MEM_W-1:0] value);
    longint unsigned lost;
    lost = 0;
    if (fill_cnt + n > DEPTH) begin
      lost = fill_cnt + n - DEPTH;
      rd_ptr = ADDR_W'(wr_ptr + n);
    end
    for (int unsigned i = 0; i < n; i++) begin
      ring_mem[wr_ptr] = value;
      wr_ptr++;
    end
    fill_cnt = (fill_cnt + n > DEPTH) ? DEPTH : fill_cnt + n;
    return lost;
  endfunction

  function automatic void ring_update(op_e op, logic [SMP_W-1:0] re, logic [SMP_W-1:0] im,
                                      logic [ZC_W-1:0] zc, logic [PC_W-1:0] pc);
    ring_rsp_t        r;
    longint unsigned  lost;
    int unsigned      want;
    int unsigned      nz;
    int unsigned      ns;
    int unsigned      total;
    logic [MEM_W-1:0] vals [MAX_POP];
    bit               pads [MAX_POP];
    logic [LVL_W-1:0] lvl;
    lost = 0;
    total = 0;
    case (op)
      OP_PUSH: begin
        lost = write_run(1, {im, re});
      end
      OP_ZEROS: begin
        if (zc > DEPTH) begin
          lost = zc - DEPTH;
        end
        lost += write_run((zc > DEPTH) ? DEPTH : zc, '0);
      end
      OP_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
        fill_cnt = 0;
        owed_zeros = '0;
      end
      default: begin
        want = (pc > MAX_POP) ? MAX_POP : pc;
        nz = (owed_zeros < want) ? owed_zeros : want;
        owed_zeros -= nz;
        want -= nz;
        ns = (fill_cnt < want) ? fill_cnt : want;
        for (int unsigned i = 0; i < nz; i++) begin
          vals[i] = '0;
          pads[i] = 1'b1;
        end
        for (int unsigned i = 0; i < ns; i++) begin
          vals[nz + i] = ring_mem[rd_ptr];
          pads[nz + i] = 1'b0;
          rd_ptr++;
        end
        fill_cnt -= ns;
        total = nz + ns;
      end
    endcase
    owed_zeros = sat_level(longint'(owed_zeros) + lost);
    lvl = sat_level(longint'(owed_zeros) + fill_cnt);
    r = '{default: '0};
    r.level = lvl;
    if (total == 0) begin
      r.last_of_run = 1'b1;
      r.lost_now = (lost > 65535) ? '1 : LOST_W'(lost);
      rsp_due.push_back(r);
    end else begin
      for (int unsigned i = 0; i < total; i++) begin
        r.out_real = vals[i][SMP_W-1:0];
        r.out_imag = vals[i][MEM_W-1:SMP_W];
        r.sample_valid = 1'b1;
        r.from_padding = pads[i];
        r.last_of_run = (i + 1 == total);
        rsp_due.push_back(r);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [LVL_W-1:0] exp_v,
                                      logic [LVL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    ring_rsp_t exp_rsp;
    if (rst_n && rsp.valid && rsp.ready) begin
      if (rsp_due.size() == 0) begin
        $error("Result arrived with no request outstanding.");
        err_cnt++;
      end else begin
        exp_rsp = rsp_due.pop_front();
        check_field("out_real", exp_rsp.out_real, rsp.out_real);
        check_field("out_imag", exp_rsp.out_imag, rsp.out_imag);
        check_field("sample_valid", exp_rsp.sample_valid, rsp.sample_valid);
        check_field("from_padding", exp_rsp.from_padding, rsp.from_padding);
        check_field("last_of_run", exp_rsp.last_of_run, rsp.last_of_run);
        check_field("lost_now", exp_rsp.lost_now, rsp.lost_now);
        check_field("level", exp_rsp.level, rsp.level);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      rsp.ready = 1'b0;
      hold_cycles--;
    end else begin
      rsp.ready = !(idle_on && $urandom_range(99) < 18);
    end
  end

  task automatic send_req(op_e op, logic [SMP_W-1:0] re, logic [SMP_W-1:0] im,
                          logic [ZC_W-1:0] zc, logic [PC_W-1:0] pc);
    while (idle_on && $urandom_range(99) < 18) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.opcode = op;
    req.in_real = re;
    req.in_imag = im;
    req.zero_count = zc;
    req.pop_count = pc;
    do @(posedge clk); while (!req.ready);
    ring_update(op, re, im, zc, pc);
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic push_sample(logic [SMP_W-1:0] re, logic [SMP_W-1:0] im);
    send_req(OP_PUSH, re, im, ZC_W'($urandom), PC_W'($urandom));
  endtask

  task automatic zero_burst(logic [ZC_W-1:0] n);
    send_req(OP_ZEROS, SMP_W'($urandom), SMP_W'($urandom), n, PC_W'($urandom));
  endtask

  task automatic pop_run(logic [PC_W-1:0] n);
    send_req(OP_POP, SMP_W'($urandom), SMP_W'($urandom), ZC_W'($urandom), n);
  endtask

  task automatic clear_ring();
    send_req(OP_CLEAR, SMP_W'($urandom), SMP_W'($urandom), ZC_W'($urandom),
             PC_W'($urandom));
  endtask

  task automatic test_directed();
    clear_ring();
    pop_run(1);
    pop_run(0);
    push_sample(16'h7FFF, 16'h8000);
    push_sample(16'h8000, 16'h7FFF);
    push_sample(16'h0000, 16'hFFFF);
    push_sample(16'h5A5A, 16'hA5A5);
    zero_burst(0);
    pop_run(2);
    zero_burst(3);
    pop_run(127);
    zero_burst(ZC_W'(DEPTH));
    push_sample(16'h1234, 16'h4321);
    zero_burst(16'd5000);
    pop_run(PC_W'(MAX_POP));
    zero_burst(16'hFFFF);
    pop_run(100);
    clear_ring();
    zero_burst(ZC_W'(DEPTH - 1));
    push_sample(16'h0001, 16'hFFFE);
    push_sample(16'hFFFF, 16'h0000);
    push_sample(16'h2468, 16'h1357);
    pop_run(5);
    clear_ring();
    pop_run(PC_W'(MAX_POP));
  endtask

  // Both pointers pass the top of the ring while real samples are stored.
  task automatic test_wraparound();
    clear_ring();
    zero_burst(ZC_W'(DEPTH - 40));
    while (fill_cnt >= MAX_POP) begin
      pop_run(PC_W'(MAX_POP));
    end
    idle_on = 1'b0;
    repeat (60) begin
      push_sample(SMP_W'($urandom), SMP_W'($urandom));
    end
    idle_on = 1'b1;
    while (fill_cnt != 0) begin
      pop_run(PC_W'($urandom_range(MAX_POP, 1)));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 150;
    repeat (30) begin
      if ($urandom_range(3) == 0) begin
        pop_run(PC_W'($urandom_range(6, 1)));
      end else begin
        push_sample(SMP_W'($urandom), SMP_W'($urandom));
      end
    end
  endtask

  task automatic test_random();
    int unsigned pick;
    repeat (120) begin
      pick = $urandom_range(99);
      if (pick < 42) begin
        push_sample(SMP_W'($urandom), SMP_W'($urandom));
      end else if (pick < 57) begin
        if ($urandom_range(14) == 0) begin
          zero_burst(ZC_W'($urandom));
        end else begin
          zero_burst(ZC_W'($urandom_range(16)));
        end
      end else if (pick < 96) begin
        if ($urandom_range(7) == 0) begin
          pop_run(PC_W'($urandom));
        end else begin
          pop_run(PC_W'($urandom_range(16, 1)));
        end
      end else begin
        clear_ring();
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    req.valid = 1'b0;
    req.opcode = OP_PUSH;
    req.in_real = '0;
    req.in_imag = '0;
    req.zero_count = '0;
    req.pop_count = '0;
    rsp.ready = 1'b0;
    wr_ptr = '0;
    rd_ptr = '0;
    fill_cnt = 0;
    owed_zeros = '0;
    err_cnt = 0;
    idle_on = 1'b1;
    hold_cycles = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_wraparound();
    test_backpressure();
    test_random();
    while (rsp_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/osr_pkg.sv
rtl/core/osr_if.sv
rtl/core/osr_ram.sv
rtl/core/osr_ctrl.sv
rtl/core/overwrite_sample_ring_with_zero_padding.sv
rtl/core/osr_chk.sv
dv/tb.sv
